[design/dsr_pkg.sv]
// dsr_pkg: shared widths, register indexes and structs of the supercell replicator
// no dependencies; used by the interfaces, the divider, the controller and the top level
package dsr_pkg;

  localparam int COORD_W    = 20;
  localparam int ELEM_W     = 7;
  localparam int ID_W       = 19;
  localparam int MULT_W     = 3;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // divider datapath: dividend 2*|num|+m, divisor 2*m
  localparam int DIV_W      = 22;
  localparam int DIVR_W     = 4;
  localparam int REM_W      = 3;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int STEP_CNT_W = 4;
  localparam int FRAC_BITS  = 16;

  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_W - 1));

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MULT_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT = 3'd3;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [MULT_W-1:0]  mult_a;
    logic [MULT_W-1:0]  mult_b;
    logic [MULT_W-1:0]  mult_c;
    logic [COUNT_W-1:0] count;
  } cfg_eff_t;

endpackage

[design/dsr_if.sv]
// dsr_if: channel interfaces of the supercell replicator (atom in, copy out, config write)
// depends on dsr_pkg for field widths
interface dsr_in_if
  import dsr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] frac_x;
  logic signed [COORD_W-1:0] frac_y;
  logic signed [COORD_W-1:0] frac_z;
  logic [ELEM_W-1:0]         element_code;

  modport source (output valid, frac_x, frac_y, frac_z, element_code, input ready);
  modport sink   (input valid, frac_x, frac_y, frac_z, element_code, output ready);
endinterface

interface dsr_out_if
  import dsr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_frac_x;
  logic signed [COORD_W-1:0] out_frac_y;
  logic signed [COORD_W-1:0] out_frac_z;
  logic [ELEM_W-1:0]         out_element;
  logic [ID_W-1:0]           out_atom_id;
  logic                      last_copy;

  modport source (output valid, out_frac_x, out_frac_y, out_frac_z, out_element,
                  out_atom_id, last_copy, input ready);
  modport sink   (input valid, out_frac_x, out_frac_y, out_frac_z, out_element,
                  out_atom_id, last_copy, output ready);
endinterface

interface dsr_cfg_if
  import dsr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/dsr_divider.sv]
// dsr_divider: shared restoring divider, two quotient bits per cycle, small divisor
// depends on dsr_pkg for div_req_t / div_rsp_t
module dsr_divider
  import dsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [STEP_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]      acc;
  logic [REM_W-1:0]      rem;
  logic [DIVR_W-1:0]     dsr;
  logic [DIV_W-1:0]      acc_next;
  logic [REM_W-1:0]      rem_next;

  // two dependent restoring steps on a 4-bit partial remainder
  always_comb begin
    logic [DIVR_W-1:0] t;
    logic [DIV_W-1:0]  a;
    logic [REM_W-1:0]  r;
    a = acc;
    r = rem;
    for (int j = 0; j < 2; j++) begin
      t = {r, a[DIV_W-1]};
      a = {a[DIV_W-2:0], 1'b0};
      if (t >= dsr) begin
        t    = t - dsr;
        a[0] = 1'b1;
      end
      r = t[REM_W-1:0];
    end
    acc_next = a;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= STEP_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = acc;

endmodule

[design/dsr_ctrl.sv]
// dsr_ctrl: sequencer that fills per-axis coordinate tables through the shared divider,
// then walks the cell shifts and registers one copy per transfer; depends on dsr_pkg, dsr_if
module dsr_ctrl
  import dsr_pkg::*;
#(
  parameter int MAX_MULT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_eff_t           eff,
  input  logic [ID_W-1:0]    id_base,
  dsr_in_if.sink             in_ch,
  dsr_out_if.source          out_ch,
  output div_req_t           div_req,
  input  div_rsp_t           div_rsp
);

  localparam int SH_W = (MAX_MULT > 1) ? $clog2(MAX_MULT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV_GO, S_DIV_WAIT, S_EMIT} state_t;
  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

  state_t state;
  axis_t  axis;

  logic signed [COORD_W-1:0] f_x, f_y, f_z;
  logic [ELEM_W-1:0]         elem;
  logic [MULT_W-1:0]         m_a, m_b, m_c;
  logic [COUNT_W-1:0]        count;
  logic [ID_W-1:0]           id_acc;
  logic [SH_W-1:0]           shift;
  logic [SH_W-1:0]           ia, ib, ic;

  logic signed [COORD_W-1:0] tab_x [MAX_MULT];
  logic signed [COORD_W-1:0] tab_y [MAX_MULT];
  logic signed [COORD_W-1:0] tab_z [MAX_MULT];

  logic                      res_valid;
  logic signed [COORD_W-1:0] res_x, res_y, res_z;
  logic [ELEM_W-1:0]         res_elem;
  logic [ID_W-1:0]           res_id;
  logic                      res_last;

  logic signed [COORD_W-1:0] f_sel;
  logic [MULT_W-1:0]         m_sel;
  logic [DIV_W-1:0]          num;
  logic [DIV_W-1:0]          mag;
  logic                      neg;
  logic signed [DIV_W-1:0]   sres;
  logic signed [COORD_W-1:0] qcoord;
  logic                      in_xfer;
  logic                      load;
  logic                      last_a, last_b, last_c;

  always_comb begin
    unique case (axis)
      AX_X:    begin f_sel = f_x; m_sel = m_a; end
      AX_Y:    begin f_sel = f_y; m_sel = m_b; end
      default: begin f_sel = f_z; m_sel = m_c; end
    endcase
  end

  // numerator f + shift in Q4.16, then magnitude for the unsigned divide
  assign num = DIV_W'(f_sel) + DIV_W'({shift, {FRAC_BITS{1'b0}}});
  assign neg = num[DIV_W-1];
  assign mag = neg ? (DIV_W'(0) - num) : num;

  assign div_req.start    = (state == S_DIV_GO);
  assign div_req.dividend = {mag[DIV_W-2:0], 1'b0} + DIV_W'(m_sel);
  assign div_req.divisor  = {m_sel, 1'b0};

  // restore sign (ties already rounded away from zero), saturate to Q4.16
  always_comb begin
    sres = neg ? (DIV_W'(0) - {1'b0, div_rsp.quotient[DIV_W-2:0]})
               : {1'b0, div_rsp.quotient[DIV_W-2:0]};
    if (sres > DIV_W'(COORD_MAX)) qcoord = COORD_W'(COORD_MAX);
    else if (sres < DIV_W'(COORD_MIN)) qcoord = COORD_W'(COORD_MIN);
    else qcoord = sres[COORD_W-1:0];
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign last_a = (MULT_W'(ia) == m_a - 1'b1);
  assign last_b = (MULT_W'(ib) == m_b - 1'b1);
  assign last_c = (MULT_W'(ic) == m_c - 1'b1);
  assign load   = (state == S_EMIT) && (!res_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (load) res_valid <= 1'b1;
      else if (out_ch.ready) res_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            f_x    <= in_ch.frac_x;
            f_y    <= in_ch.frac_y;
            f_z    <= in_ch.frac_z;
            elem   <= in_ch.element_code;
            m_a    <= eff.mult_a;
            m_b    <= eff.mult_b;
            m_c    <= eff.mult_c;
            count  <= eff.count;
            id_acc <= id_base;
            axis   <= AX_X;
            shift  <= '0;
            state  <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (axis)
              AX_X:    tab_x[shift] <= qcoord;
              AX_Y:    tab_y[shift] <= qcoord;
              default: tab_z[shift] <= qcoord;
            endcase
            if (MULT_W'(shift) == m_sel - 1'b1) begin
              shift <= '0;
              unique case (axis)
                AX_X:    begin axis <= AX_Y; state <= S_DIV_GO; end
                AX_Y:    begin axis <= AX_Z; state <= S_DIV_GO; end
                default: begin
                  ia    <= '0;
                  ib    <= '0;
                  ic    <= '0;
                  state <= S_EMIT;
                end
              endcase
            end else begin
              shift <= shift + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_EMIT: begin
          if (load) begin
            res_x    <= tab_x[ia];
            res_y    <= tab_y[ib];
            res_z    <= tab_z[ic];
            res_elem <= elem;
            res_id   <= id_acc;
            res_last <= last_a && last_b && last_c;
            id_acc   <= id_acc + ID_W'(count);
            if (last_c) begin
              ic <= '0;
              if (last_b) begin
                ib <= '0;
                ia <= ia + 1'b1;
              end else begin
                ib <= ib + 1'b1;
              end
            end else begin
              ic <= ic + 1'b1;
            end
            if (last_a && last_b && last_c) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.out_frac_x  = res_x;
  assign out_ch.out_frac_y  = res_y;
  assign out_ch.out_frac_z  = res_z;
  assign out_ch.out_element = res_elem;
  assign out_ch.out_atom_id = res_id;
  assign out_ch.last_copy   = res_last;

endmodule

[design/diagonal_supercell_replicator_top.sv]
// diagonal_supercell_replicator_top: config registers, atom index, divider and sequencer
// depends on dsr_pkg, dsr_if, dsr_divider, dsr_ctrl
//
// Replicates one atom per input transfer into mult_a*mult_b*mult_c copies of a diagonal
// supercell. Each copy carries (f+i)/mult per axis in signed Q4.16, rounded to nearest with
// ties away from zero, the element code, and identifier rank*atom_count + atom_index + 1;
// copies leave ia outermost, ic innermost, last_copy marking the final one. Multipliers of 0
// act as 1 and above MAX_MULT act as MAX_MULT; atom_count 0 acts as 1, above MAX_ATOMS as
// MAX_ATOMS. The atom index advances per atom and wraps at the effective count. Throughput:
// one atom at a time. After the atom transfer the block fills one table entry at a time in
// the shared divider (11 two-bit steps plus issue and write-back), a+b+c entries in all, then
// emits one copy per cycle while the output side keeps taking them. Input ready is high only
// while the sequencer is idle; the last copy may still sit in the output register when the
// next atom is taken. Config writes are always ready and should only be issued while idle.
module diagonal_supercell_replicator_top
  import dsr_pkg::*;
#(
  parameter int MAX_ATOMS = 4096,
  parameter int MAX_MULT  = 4
) (
  input  logic      clk,
  input  logic      rst,
  dsr_in_if.sink    in_ch,
  dsr_out_if.source out_ch,
  dsr_cfg_if.sink   cfg
);

  localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

  // configuration registers, raw values as written
  logic [MULT_W-1:0]  mult_a;
  logic [MULT_W-1:0]  mult_b;
  logic [MULT_W-1:0]  mult_c;
  logic [COUNT_W-1:0] atom_count;

  // index of the next source atom
  logic [IDX_W-1:0]   atom_index;

  cfg_eff_t           eff;
  logic [ID_W-1:0]    id_base;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // config writes never stall
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_a     <= MULT_W'(1);
      mult_b     <= MULT_W'(1);
      mult_c     <= MULT_W'(1);
      atom_count <= COUNT_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MULT_A:     mult_a     <= cfg.data[MULT_W-1:0];
        REG_MULT_B:     mult_b     <= cfg.data[MULT_W-1:0];
        REG_MULT_C:     mult_c     <= cfg.data[MULT_W-1:0];
        REG_ATOM_COUNT: atom_count <= cfg.data[COUNT_W-1:0];
        default:        ; // writes beyond the register list are dropped
      endcase
    end
  end

  // clamp multipliers into 1..MAX_MULT
  function automatic logic [MULT_W-1:0] clamp_mult(input logic [MULT_W-1:0] m);
    logic [MULT_W-1:0] r;
    if (m == '0) r = MULT_W'(1);
    else if (32'(m) > MAX_MULT) r = MULT_W'(MAX_MULT);
    else r = m;
    return r;
  endfunction

  always_comb begin
    eff.mult_a = clamp_mult(mult_a);
    eff.mult_b = clamp_mult(mult_b);
    eff.mult_c = clamp_mult(mult_c);
    // clamp atom count into 1..MAX_ATOMS
    if (atom_count == '0) eff.count = COUNT_W'(1);
    else if (32'(atom_count) > MAX_ATOMS) eff.count = COUNT_W'(MAX_ATOMS);
    else eff.count = atom_count;
  end

  // identifier of the first copy is the atom index plus one
  assign id_base = ID_W'(atom_index) + ID_W'(1);

  // advance per atom transfer, wrap at the effective count (or if already beyond it)
  always_ff @(posedge clk) begin
    if (rst) begin
      atom_index <= '0;
    end else if (in_ch.valid && in_ch.ready) begin
      if (32'(atom_index) + 1 >= 32'(eff.count)) atom_index <= '0;
      else atom_index <= atom_index + 1'b1;
    end
  end

  // shared iterative divider for every coordinate quotient
  dsr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer: table fill through the divider, then copy emission
  dsr_ctrl #(
    .MAX_MULT (MAX_MULT)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .eff     (eff),
    .id_base (id_base),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

`ifndef SYNTHESIS
  // an accepted atom keeps the input closed while its copies are produced
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after an atom transfer");

  // while idle, only the final copy of the previous atom may still wait at the output
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready && out_ch.valid |-> out_ch.last_copy)
    else $error("sequencer idle with a non-final copy pending");

  // identifiers start at one
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.out_atom_id != '0)
    else $error("copy with zero identifier");

  // the divider is never restarted while a quotient is due
  a_div_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_req.start)
    else $error("divider started on consecutive cycles");
`endif

endmodule
